FILE: hw/rtl/gdsc_pkg.sv
// Shared types and constants for the garage door stepper controller.
package gdsc_pkg;

    localparam int DIST_W  = 11;
    localparam int STEP_W  = 12;
    localparam int ECHO_W  = 16;
    localparam int NIB_W   = 4;
    localparam int CFG_W   = 12;

    // echo/2 is at most 15 bits; x/29 == (x * 36158) >> 20 for every x below 2^17
    localparam int HALF_W      = ECHO_W - 1;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 20;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 16'd36158;
    localparam int PROD_W      = HALF_W + RECIP_W;

    typedef enum logic [1:0] {
        FUNC_MEASURE = 2'd0,
        FUNC_NOISE   = 2'd1,
        FUNC_TICK    = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_FAR    = 2'd0,
        CFG_MID    = 2'd1,
        CFG_NEAR   = 2'd2,
        CFG_TRAVEL = 2'd3
    } t_cfg_idx;

    localparam logic [DIST_W-1:0] FAR_RST    = 11'd12;
    localparam logic [DIST_W-1:0] MID_RST    = 11'd7;
    localparam logic [DIST_W-1:0] NEAR_RST   = 11'd4;
    localparam logic [STEP_W-1:0] TRAVEL_RST = 12'd700;

    localparam logic [NIB_W-1:0] LED_NEAR = 4'h1;
    localparam logic [NIB_W-1:0] LED_MID  = 4'h2;
    localparam logic [NIB_W-1:0] LED_FAR  = 4'h4;
    localparam logic [NIB_W-1:0] LED_DOOR = 4'h8;
    localparam logic [NIB_W-1:0] LED_PROX = 4'h7;
    localparam logic [NIB_W-1:0] PH_FIRST_OPEN  = 4'h8;
    localparam logic [NIB_W-1:0] PH_FIRST_CLOSE = 4'h1;

    typedef struct packed {
        logic [1:0]        func;
        logic [ECHO_W-1:0] echo_time;
    } t_in_item;

    typedef struct packed {
        logic [NIB_W-1:0]  coil_drive;
        logic [NIB_W-1:0]  leds;
        logic [DIST_W-1:0] distance;
        logic              door_open;
        logic              moving;
        logic              ranging_enabled;
    } t_out_item;

    typedef struct packed {
        logic [1:0]       index;
        logic [CFG_W-1:0] data;
    } t_cfg_item;

endpackage

FILE: hw/rtl/gdsc_if.sv
// Valid/ready channel interfaces for the garage door stepper controller.
interface gdsc_in_if import gdsc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface gdsc_out_if import gdsc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface gdsc_cfg_if import gdsc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

FILE: hw/rtl/garage_door_stepper_controller.sv
// Garage door stepper controller: event handling, stepper sequencing, result register.
//
// Channels: i_in takes one event item (func, echo_time), o_out gives one result
// item per event (coil_drive, leds, distance, door_open, moving,
// ranging_enabled), showing the state after that event. i_cfg writes the four
// registers (far, mid, near threshold, travel steps); it is always ready.
// A measure item converts echo_time to centimetres, (echo/2)/29, by a constant
// reciprocal multiply and lights proximity LEDs; at the near threshold the
// door starts opening. A noise item starts closing an open door. Tick items
// step the motor coils until the travel count is reached.
// The result is registered: it becomes valid in the cycle after the input is accepted.
// Throughput: one item per cycle while the receiver does not stall; the event is resolved by
// one 15x16 multiply and threshold compares between the state registers and the result register.
// Backpressure: the result register holds while o_out.ready is low; i_in.ready
// is low only while a result waits and the receiver stalls.
// Reset (i_rst_n low, synchronous): door closed, ranging enabled, stepper idle,
// coils and LEDs off, registers at their default values, no result pending.
module garage_door_stepper_controller import gdsc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gdsc_cfg_if.sink     i_cfg,
    gdsc_in_if.sink      i_in,
    gdsc_out_if.source   o_out
);

    logic [DIST_W-1:0] r_far_th, r_mid_th, r_near_th;
    logic [STEP_W-1:0] r_travel;

    logic              r_door_open, n_door_open;
    logic              r_noise_flag, n_noise_flag;
    logic              r_ranging, n_ranging;
    logic              r_moving, n_moving;
    logic [STEP_W-1:0] r_step_cnt, n_step_cnt;
    logic [NIB_W-1:0]  r_phase, n_phase;
    logic [NIB_W-1:0]  r_coil, n_coil;
    logic [NIB_W-1:0]  r_leds, n_leds;
    logic [DIST_W-1:0] r_dist, n_dist;

    logic              r_out_valid;
    t_out_item         r_out;

    logic              w_accept;
    logic [PROD_W-1:0] w_prod;
    logic [DIST_W-1:0] w_dist;
    logic [STEP_W-1:0] w_limit;
    logic [STEP_W-1:0] w_cnt_inc;
    logic [NIB_W-1:0]  w_phase_step;
    t_func             w_func;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_accept    = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_far_th  <= FAR_RST;
            r_mid_th  <= MID_RST;
            r_near_th <= NEAR_RST;
            r_travel  <= TRAVEL_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.item.index))
                CFG_FAR:    r_far_th  <= i_cfg.item.data[DIST_W-1:0];
                CFG_MID:    r_mid_th  <= i_cfg.item.data[DIST_W-1:0];
                CFG_NEAR:   r_near_th <= i_cfg.item.data[DIST_W-1:0];
                CFG_TRAVEL: r_travel  <= i_cfg.item.data;
                default: ;
            endcase
        end
    end

    assign w_func = t_func'(i_in.item.func);
    assign w_prod = i_in.item.echo_time[ECHO_W-1:1] * RECIP_MUL;
    assign w_dist = w_prod[RECIP_SHIFT +: DIST_W];
    assign w_limit = (r_travel == '0) ? STEP_W'(1) : r_travel;
    assign w_cnt_inc = r_step_cnt + STEP_W'(1);

    // closing shifts left and wraps to bit 0, opening shifts right and wraps to bit 3
    always_comb begin
        if (r_door_open) begin
            w_phase_step = {r_phase[NIB_W-2:0], 1'b0};
            if (w_phase_step == '0) w_phase_step = PH_FIRST_CLOSE;
        end else begin
            w_phase_step = {1'b0, r_phase[NIB_W-1:1]};
            if (w_phase_step == '0) w_phase_step = PH_FIRST_OPEN;
        end
    end

    always_comb begin
        n_door_open  = r_door_open;
        n_noise_flag = r_noise_flag;
        n_ranging    = r_ranging;
        n_moving     = r_moving;
        n_step_cnt   = r_step_cnt;
        n_phase      = r_phase;
        n_coil       = r_coil;
        n_leds       = r_leds;
        n_dist       = r_dist;
        case (w_func)
            FUNC_TICK: begin
                if (r_moving) begin
                    n_phase    = w_phase_step;
                    n_coil     = ~w_phase_step;
                    n_step_cnt = w_cnt_inc;
                    if (w_cnt_inc >= w_limit) begin
                        n_moving    = 1'b0;
                        n_door_open = !r_door_open;
                        // closing keeps only the door bit, as the original firmware did
                        n_leds      = r_door_open ? (r_leds & LED_DOOR) : (r_leds | LED_DOOR);
                    end
                end
            end
            FUNC_MEASURE: begin
                if (!r_moving && r_ranging) begin
                    n_dist = w_dist;
                    if (w_dist <= r_far_th) n_leds = n_leds | LED_FAR;
                    if (w_dist <= r_mid_th) n_leds = n_leds | LED_MID;
                    if (w_dist <= r_near_th) begin
                        n_leds       = n_leds | LED_NEAR;
                        n_ranging    = 1'b0;
                        n_noise_flag = 1'b0;
                        n_moving     = 1'b1;
                        n_step_cnt   = '0;
                        n_phase      = '0;
                    end
                end
            end
            FUNC_NOISE: begin
                if (!r_moving) begin
                    if (r_door_open) begin
                        n_noise_flag = 1'b1;
                        n_ranging    = 1'b1;
                        n_moving     = 1'b1;
                        n_step_cnt   = '0;
                        n_phase      = '0;
                    end else if (r_noise_flag) begin
                        n_noise_flag = 1'b0;
                        n_leds       = r_leds & LED_PROX;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_door_open  <= 1'b0;
            r_noise_flag <= 1'b0;
            r_ranging    <= 1'b1;
            r_moving     <= 1'b0;
            r_step_cnt   <= '0;
            r_phase      <= '0;
            r_coil       <= '0;
            r_leds       <= '0;
            r_dist       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_door_open  <= n_door_open;
                r_noise_flag <= n_noise_flag;
                r_ranging    <= n_ranging;
                r_moving     <= n_moving;
                r_step_cnt   <= n_step_cnt;
                r_phase      <= n_phase;
                r_coil       <= n_coil;
                r_leds       <= n_leds;
                r_dist       <= n_dist;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out.coil_drive      <= n_coil;
            r_out.leds            <= n_leds;
            r_out.distance        <= n_dist;
            r_out.door_open       <= n_door_open;
            r_out.moving          <= n_moving;
            r_out.ranging_enabled <= n_ranging;
        end
    end

`ifndef NO_ASSERTIONS
    // an opening travel only starts from a near measurement, which turns ranging off
    a_open_no_ranging: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_moving && !r_door_open) |-> !r_ranging)
        else $error("ranging enabled during opening travel");

    a_noise_ranging: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_noise_flag |-> r_ranging)
        else $error("noise flag set with ranging disabled");

    a_coil_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_coil == '0) || ($countones(r_coil) == NIB_W - 1))
        else $error("coil drive is not an active-low single phase");

    a_result_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_out.moving == r_moving && r_out.door_open == r_door_open))
        else $error("result does not reflect updated state");
`endif

endmodule

FILE: tb/door_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the garage door controller: tracks state from accepted items, compares results.
module door_result_checker import gdsc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    gdsc_cfg_if  i_cfg_mon,
    gdsc_in_if   i_evt_mon,
    gdsc_out_if  i_res_mon,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int ECHO_US_PER_CM = 29;

    // register copies
    logic [DIST_W-1:0] far_lim;
    logic [DIST_W-1:0] mid_lim;
    logic [DIST_W-1:0] near_lim;
    logic [STEP_W-1:0] travel_len;

    // door state
    logic              door_open_q;
    logic              noise_heard_q;
    logic              ranging_q;
    logic              moving_q;
    logic [STEP_W-1:0] steps_done;
    logic [NIB_W-1:0]  phase_q;
    logic [NIB_W-1:0]  coil_q;
    logic [NIB_W-1:0]  led_q;
    logic [DIST_W-1:0] dist_q;

    t_out_item expected_results[$];

    task automatic reset_door();
        far_lim       = FAR_RST;
        mid_lim       = MID_RST;
        near_lim      = NEAR_RST;
        travel_len    = TRAVEL_RST;
        door_open_q   = 1'b0;
        noise_heard_q = 1'b0;
        ranging_q     = 1'b1;
        moving_q      = 1'b0;
        steps_done    = '0;
        phase_q       = '0;
        coil_q        = '0;
        led_q         = '0;
        dist_q        = '0;
    endtask

    task automatic begin_travel();
        moving_q   = 1'b1;
        steps_done = '0;
        phase_q    = '0;
    endtask

    task automatic advance_stepper();
        logic [STEP_W-1:0] lim;
        lim = (travel_len == '0) ? STEP_W'(1) : travel_len;
        if (door_open_q) begin
            // closing: rotate left through the coils
            phase_q = {phase_q[NIB_W-2:0], 1'b0};
            if (phase_q == '0) phase_q = PH_FIRST_CLOSE;
        end else begin
            phase_q = phase_q >> 1;
            if (phase_q == '0) phase_q = PH_FIRST_OPEN;
        end
        coil_q     = ~phase_q;
        steps_done = steps_done + 1'b1;
        if (steps_done >= lim) begin
            moving_q = 1'b0;
            if (!door_open_q) begin
                door_open_q = 1'b1;
                led_q       = led_q | LED_DOOR;
            end else begin
                // door LED stays lit after closing; only proximity LEDs drop
                door_open_q = 1'b0;
                led_q       = led_q & LED_DOOR;
            end
        end
    endtask

    task automatic predict_door(input t_in_item ev, output t_out_item res);
        int half_echo;
        case (t_func'(ev.func))
            FUNC_TICK: begin
                if (moving_q) advance_stepper();
            end
            FUNC_MEASURE: begin
                if (!moving_q && ranging_q) begin
                    half_echo = int'(ev.echo_time) >> 1;
                    dist_q    = DIST_W'(half_echo / ECHO_US_PER_CM);
                    if (dist_q <= far_lim) led_q = led_q | LED_FAR;
                    if (dist_q <= mid_lim) led_q = led_q | LED_MID;
                    if (dist_q <= near_lim) begin
                        led_q         = led_q | LED_NEAR;
                        ranging_q     = 1'b0;
                        noise_heard_q = 1'b0;
                        begin_travel();
                    end
                end
            end
            FUNC_NOISE: begin
                if (!moving_q) begin
                    if (door_open_q) begin
                        noise_heard_q = 1'b1;
                        ranging_q     = 1'b1;
                        begin_travel();
                    end else if (noise_heard_q) begin
                        noise_heard_q = 1'b0;
                        led_q         = led_q & LED_PROX;
                    end
                end
            end
            default: ;
        endcase
        res.coil_drive      = coil_q;
        res.leds            = led_q;
        res.distance        = dist_q;
        res.door_open       = door_open_q;
        res.moving          = moving_q;
        res.ranging_enabled = ranging_q;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            reset_door();
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                case (t_cfg_idx'(i_cfg_mon.item.index))
                    CFG_FAR:    far_lim    = i_cfg_mon.item.data[DIST_W-1:0];
                    CFG_MID:    mid_lim    = i_cfg_mon.item.data[DIST_W-1:0];
                    CFG_NEAR:   near_lim   = i_cfg_mon.item.data[DIST_W-1:0];
                    CFG_TRAVEL: travel_len = i_cfg_mon.item.data[STEP_W-1:0];
                    default: ;
                endcase
            end
            // results leave before this edge's event is predicted
            if (i_res_mon.valid && i_res_mon.ready) begin
                got = i_res_mon.item;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing, actual %h",
                             $time, got);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("coil_drive", want.coil_drive, got.coil_drive);
                    compare_field("leds", want.leds, got.leds);
                    compare_field("distance", want.distance, got.distance);
                    compare_field("door_open", want.door_open, got.door_open);
                    compare_field("moving", want.moving, got.moving);
                    compare_field("ranging_enabled", want.ranging_enabled,
                                  got.ranging_enabled);
                end
            end
            if (i_evt_mon.valid && i_evt_mon.ready) begin
                predict_door(i_evt_mon.item, want);
                expected_results.push_back(want);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

FILE: tb/garage_door_stepper_controller_tb.sv
`timescale 1ns / 100ps
// Testbench top for the garage door controller: clock, reset, event and register stimulus, verdict.
module garage_door_stepper_controller_tb;
    import gdsc_pkg::*;

    localparam int RUN_LIMIT    = 400000;
    localparam int TARGET_ITEMS = 550;
    localparam int MAX_ECHO     = 65535;
    localparam int US_PER_CM    = 58;    // round trip
    localparam int MAX_DIST     = 1129;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count = 0;
    int   fail_count;
    int   results_pending;
    int   counted_items = 0;
    int   stall_left = 0;
    bit   calm = 1'b0;

    logic [CFG_W-1:0] near_setting;
    logic [CFG_W-1:0] travel_setting;

    gdsc_cfg_if cfg_ch ();
    gdsc_in_if  evt_ch ();
    gdsc_out_if res_ch ();

    garage_door_stepper_controller u_top (
        .i_clk,
        .i_rst_n,
        .i_cfg (cfg_ch),
        .i_in  (evt_ch),
        .o_out (res_ch)
    );

    door_result_checker u_checker (
        .i_clk,
        .i_rst_n,
        .i_cfg_mon    (cfg_ch),
        .i_evt_mon    (evt_ch),
        .i_res_mon    (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int idle_draw();
        if (calm) return 0;
        return int'($urandom_range(0, 13));
    endfunction

    // receiver: draws a fresh random stall after every accepted result, none while calm
    always @(posedge i_clk) begin
        if (res_ch.valid && res_ch.ready) stall_left = idle_draw();
        if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // valid stays high into the next item when no gap is drawn
    task automatic send_event(input t_func f, input logic [ECHO_W-1:0] echo);
        int       gap;
        t_in_item ev;
        gap = idle_draw();
        ev.func      = f;
        ev.echo_time = echo;
        if (gap > 0) begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        evt_ch.valid <= 1'b1;
        evt_ch.item  <= ev;
        do @(posedge i_clk); while (!evt_ch.ready);
    endtask

    task automatic pause_events();
        evt_ch.valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        t_cfg_item w;
        w.index = idx;
        w.data  = val;
        cfg_ch.valid <= 1'b1;
        cfg_ch.item  <= w;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic write_settings(input logic [CFG_W-1:0] far, input logic [CFG_W-1:0] mid,
                                  input logic [CFG_W-1:0] near,
                                  input logic [CFG_W-1:0] travel);
        pause_events();
        put_reg(CFG_FAR, far);
        put_reg(CFG_MID, mid);
        put_reg(CFG_NEAR, near);
        put_reg(CFG_TRAVEL, travel);
        cfg_ch.valid   <= 1'b0;
        near_setting   = near;
        travel_setting = travel;
    endtask

    function automatic logic [CFG_W-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return CFG_W'(1200);
            2:       return CFG_W'($urandom_range(0, 1200));
            default: return CFG_W'($urandom_range(0, 24));
        endcase
    endfunction

    // ticks for one travel, now and then one extra, with the odd event thrown in that motion must swallow
    task automatic drive_travel();
        int    steps;
        t_func stray[3];
        stray = '{FUNC_MEASURE, FUNC_NOISE, FUNC_NONE};
        steps = ((travel_setting == '0) ? 1 : int'(travel_setting)) + $urandom_range(0, 1);
        repeat (steps) begin
            if ($urandom_range(0, 7) == 0)
                send_event(stray[$urandom_range(0, 2)], ECHO_W'($urandom));
            send_event(FUNC_TICK, ECHO_W'($urandom));
            counted_items++;
        end
    endtask

    // approach, open, close, then usually acknowledge the noise
    task automatic run_door_cycle();
        int target_cm;
        int echo;
        repeat ($urandom_range(0, 2)) begin
            send_event(FUNC_MEASURE, ECHO_W'($urandom));
            counted_items++;
        end
        target_cm = $urandom_range(0, (near_setting > MAX_DIST) ? MAX_DIST : int'(near_setting));
        echo = target_cm * US_PER_CM + $urandom_range(0, US_PER_CM - 1);
        if (echo > MAX_ECHO) echo = MAX_ECHO;
        send_event(FUNC_MEASURE, ECHO_W'(echo));
        counted_items++;
        drive_travel();
        if ($urandom_range(0, 3) == 0) send_event(FUNC_MEASURE, ECHO_W'($urandom));
        send_event(FUNC_NOISE, ECHO_W'($urandom));
        counted_items++;
        drive_travel();
        if ($urandom_range(0, 2) != 0) begin
            send_event(FUNC_NOISE, ECHO_W'($urandom));
            counted_items++;
        end
    endtask

    initial begin
        logic [CFG_W-1:0] travel;
        cfg_ch.valid = 1'b0;
        cfg_ch.item  = '0;
        evt_ch.valid = 1'b0;
        evt_ch.item  = '0;
        res_ch.ready = 1'b0;
        i_rst_n      = 1'b0;
        near_setting   = CFG_W'(NEAR_RST);
        travel_setting = CFG_W'(TRAVEL_RST);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: idle tick, unused code, noise with no flag, LED bands
        send_event(FUNC_TICK, 16'h0000);
        send_event(FUNC_NONE, 16'hFFFF);
        send_event(FUNC_NOISE, 16'hFFFF);
        send_event(FUNC_MEASURE, 16'hFFFF);
        send_event(FUNC_MEASURE, 16'd600);
        send_event(FUNC_MEASURE, 16'd406);

        // zero travel: each travel ends on its first tick
        write_settings(12'd1200, 12'd0, 12'd0, 12'd0);
        send_event(FUNC_MEASURE, 16'hFFFF);
        send_event(FUNC_MEASURE, 16'd57);
        send_event(FUNC_MEASURE, 16'd0);     // moving
        send_event(FUNC_NOISE, 16'd0);       // moving
        send_event(FUNC_TICK, 16'd0);
        send_event(FUNC_TICK, 16'd0);        // idle
        send_event(FUNC_MEASURE, 16'd0);     // ranging off
        send_event(FUNC_NOISE, 16'd0);       // closes
        send_event(FUNC_TICK, 16'd0);
        send_event(FUNC_NOISE, 16'd0);       // clears flag and door LED
        send_event(FUNC_NOISE, 16'd0);       // no effect

        // longest travel, cut short by lowering the step count
        write_settings(12'd0, 12'd1200, 12'd1200, 12'd4095);
        send_event(FUNC_MEASURE, 16'hFFFF);
        repeat (6) send_event(FUNC_TICK, 16'hFFFF);
        write_settings(12'd0, 12'd1200, 12'd1200, 12'd1);
        send_event(FUNC_TICK, 16'h5555);
        send_event(FUNC_NOISE, 16'hAAAA);
        send_event(FUNC_TICK, 16'h0000);

        while (counted_items < TARGET_ITEMS) begin
            case ($urandom_range(0, 19))
                0:       travel = '0;
                1:       travel = CFG_W'($urandom_range(20, 64));
                default: travel = CFG_W'($urandom_range(1, 6));
            endcase
            write_settings(pick_threshold(), pick_threshold(), pick_threshold(), travel);
            repeat ($urandom_range(2, 5)) begin
                if ($urandom_range(0, 9) < 2)
                    send_event(t_func'($urandom_range(0, 3)), ECHO_W'($urandom));
                else
                    run_door_cycle();
            end
            calm = ($urandom_range(0, 4) == 0);
        end

        pause_events();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: garage_door_stepper_controller.f
hw/rtl/gdsc_pkg.sv
hw/rtl/gdsc_if.sv
hw/rtl/garage_door_stepper_controller.sv
tb/door_result_checker.sv
tb/garage_door_stepper_controller_tb.sv
